// ===== design/mls_pkg.sv =====
package mls_pkg;

	localparam int NUM_PORTS     = 16;
	localparam int TABLE_ENTRIES = 64;

	// table is banked into lanes, one row of lanes read per cycle
	localparam int LANES  = 4;
	localparam int LANE_W = $clog2(LANES);
	localparam int ROWS   = TABLE_ENTRIES / LANES;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W  = ROW_W + LANE_W;

	localparam int MAC_W      = 48;
	localparam int PORT_W     = 4;
	localparam int TIME_W     = 32;
	localparam int MASK_W     = 16;
	localparam int PCNT_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int GROUP_BIT  = 40;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	localparam logic [PCNT_W-1:0] PORT_COUNT_RST = PCNT_W'(16);
	localparam logic [TIME_W-1:0] AGE_LIMIT_RST  = TIME_W'(300);

	localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT  = 2'd1;

	localparam logic [1:0] ACT_FLOOD = 2'd0;
	localparam logic [1:0] ACT_FWD   = 2'd1;
	localparam logic [1:0] ACT_DROP  = 2'd2;

	localparam logic [1:0] LEARN_REFRESH = 2'd0;
	localparam logic [1:0] LEARN_NEW     = 2'd1;
	localparam logic [1:0] LEARN_FULL    = 2'd2;

	typedef struct packed {
		logic [PORT_W-1:0] in_port;
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
		logic [TIME_W-1:0] stamp;
		logic              grp_dst;
		logic              same_mac;
		logic [MASK_W-1:0] flood_mask;
	} item_t;

	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [PORT_W-1:0] out_port;
		logic [MASK_W-1:0] port_mask;
		logic [1:0]        learn_status;
	} result_t;

	typedef struct packed {
		logic  full;
		logic  empty;
	} q_status_t;

endpackage

// ===== design/mls_front.sv =====
module mls_front (
	input  logic                      start,
	output logic                      busy,
	input  logic [mls_pkg::PORT_W-1:0] in_port,
	input  logic [mls_pkg::MAC_W-1:0]  src_mac,
	input  logic [mls_pkg::MAC_W-1:0]  dst_mac,
	input  logic [mls_pkg::TIME_W-1:0] arrival_time,
	input  logic [mls_pkg::PCNT_W-1:0] port_count,
	input  mls_pkg::q_status_t         q_status,
	output logic                      push,
	output mls_pkg::item_t            item
);
	import mls_pkg::*;

	logic [PCNT_W-1:0] n_ports;
	logic [MASK_W-1:0] flood;

	assign busy = q_status.full;
	assign push = start && !q_status.full;

	// flood set: ports below the saturated port count, ingress excluded
	assign n_ports = (port_count > PCNT_W'(NUM_PORTS)) ? PCNT_W'(NUM_PORTS) : port_count;

	always_comb begin
		for (int i = 0; i < MASK_W; i++) begin
			flood[i] = (PCNT_W'(i) < n_ports) && (PORT_W'(i) != in_port);
		end
	end

	always_comb begin
		item.in_port    = in_port;
		item.src_mac    = src_mac;
		item.dst_mac    = dst_mac;
		item.stamp      = arrival_time;
		item.grp_dst    = dst_mac[GROUP_BIT];
		item.same_mac   = (dst_mac == src_mac);
		item.flood_mask = flood;
	end

endmodule

// ===== design/mls_fifo.sv =====
module mls_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mls_pkg::item_t     wdata,
	input  logic               pop,
	output mls_pkg::item_t     rdata,
	output mls_pkg::q_status_t status
);
	import mls_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;

	assign status.full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign status.empty = (count_q == '0);
	assign rdata        = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== design/mls_back.sv =====
module mls_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mls_pkg::q_status_t         q_status,
	input  mls_pkg::item_t             q_item,
	output logic                       pop,
	input  logic [mls_pkg::TIME_W-1:0] age_limit,
	output logic                       done,
	output mls_pkg::result_t           result
);
	import mls_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0]         state_q;
	item_t              item_q;
	logic [ROW_W-1:0]   addr_q;
	logic               issue_q;
	logic               rd_en;
	logic               rd_vld_s1;
	logic               last_s1;
	logic [ROW_W-1:0]   row_s1;
	entry_t             rdata_s1 [LANES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic               src_fnd_q;
	logic [IDX_W-1:0]   src_idx_q;
	logic               free_fnd_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               dst_fnd_q;
	logic [PORT_W-1:0]  dst_port_q;
	logic [TIME_W-1:0]  dst_stamp_q;

	logic               src_any;
	logic [LANE_W-1:0]  src_lane;
	logic               free_any;
	logic [LANE_W-1:0]  free_lane;
	logic               dst_any;
	logic [LANE_W-1:0]  dst_lane;

	logic [1:0]         learn;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wentry;
	logic               fresh;
	logic [PORT_W-1:0]  fport;
	logic [TIME_W-1:0]  age;
	result_t            res;

	assign pop   = (state_q == ST_IDLE) && !q_status.empty;
	assign rd_en = (state_q == ST_SCAN) && issue_q;

	// table RAM, one bank per lane
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		entry_t mem_q [ROWS];
		logic   we;

		assign we = wr_en && (state_q == ST_DECIDE) && (wr_idx[LANE_W-1:0] == LANE_W'(l));

		always_ff @(posedge clk) begin
			if (rd_en) begin
				rdata_s1[l] <= mem_q[addr_q];
			end
			if (we) begin
				mem_q[wr_idx[IDX_W-1:LANE_W]] <= wentry;
			end
		end
	end

	// per-row compare, lowest lane wins
	always_comb begin
		logic v;
		src_any   = 1'b0;
		src_lane  = '0;
		free_any  = 1'b0;
		free_lane = '0;
		dst_any   = 1'b0;
		dst_lane  = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			v = valid_q[{row_s1, LANE_W'(l)}];
			if (v && rdata_s1[l].mac == item_q.src_mac) begin
				src_any  = 1'b1;
				src_lane = LANE_W'(l);
			end
			if (v && rdata_s1[l].mac == item_q.dst_mac) begin
				dst_any  = 1'b1;
				dst_lane = LANE_W'(l);
			end
			if (!v) begin
				free_any  = 1'b1;
				free_lane = LANE_W'(l);
			end
		end
	end

	// learn first, then forwarding decision on the table as it stands after learning
	always_comb begin
		wentry.mac   = item_q.src_mac;
		wentry.port  = item_q.in_port;
		wentry.stamp = item_q.stamp;
		if (src_fnd_q) begin
			learn  = LEARN_REFRESH;
			wr_en  = 1'b1;
			wr_idx = src_idx_q;
		end else if (free_fnd_q) begin
			learn  = LEARN_NEW;
			wr_en  = 1'b1;
			wr_idx = free_idx_q;
		end else begin
			learn  = LEARN_FULL;
			wr_en  = 1'b0;
			wr_idx = free_idx_q;
		end

		age = item_q.stamp - dst_stamp_q;
		if (item_q.grp_dst) begin
			fresh = 1'b0;
			fport = dst_port_q;
		end else if (item_q.same_mac) begin
			// destination is the entry just learned: age zero on the ingress port
			fresh = (learn != LEARN_FULL) && (age_limit != '0);
			fport = item_q.in_port;
		end else begin
			fresh = dst_fnd_q && (age < age_limit);
			fport = dst_port_q;
		end

		res.learn_status = learn;
		if (fresh && fport == item_q.in_port) begin
			res.action    = ACT_DROP;
			res.out_port  = '0;
			res.port_mask = '0;
		end else if (fresh) begin
			res.action    = ACT_FWD;
			res.out_port  = fport;
			res.port_mask = MASK_W'(1) << fport;
		end else begin
			res.action    = ACT_FLOOD;
			res.out_port  = '0;
			res.port_mask = item_q.flood_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_item;
		end
		row_s1  <= addr_q;
		last_s1 <= (addr_q == ROW_W'(ROWS-1));
		if (rd_vld_s1) begin
			if (!src_fnd_q && src_any) begin
				src_idx_q <= {row_s1, src_lane};
			end
			if (!free_fnd_q && free_any) begin
				free_idx_q <= {row_s1, free_lane};
			end
			if (!dst_fnd_q && dst_any) begin
				dst_port_q  <= rdata_s1[dst_lane].port;
				dst_stamp_q <= rdata_s1[dst_lane].stamp;
			end
		end
		if (state_q == ST_DECIDE) begin
			result <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			addr_q     <= '0;
			issue_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			valid_q    <= '0;
			src_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
			dst_fnd_q  <= 1'b0;
			done       <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			done      <= (state_q == ST_DECIDE);
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q    <= ST_SCAN;
						addr_q     <= '0;
						issue_q    <= 1'b1;
						src_fnd_q  <= 1'b0;
						free_fnd_q <= 1'b0;
						dst_fnd_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						if (addr_q == ROW_W'(ROWS-1)) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + ROW_W'(1);
						end
					end
					if (rd_vld_s1) begin
						src_fnd_q  <= src_fnd_q || src_any;
						free_fnd_q <= free_fnd_q || free_any;
						dst_fnd_q  <= dst_fnd_q || dst_any;
						if (last_s1) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (wr_en) begin
						valid_q[wr_idx] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/mac_learning_switch.sv =====
// channel   signals                                             transfer at clock edge
// input     start busy in_port src_mac dst_mac arrival_time     start high, busy low
// result    done action out_port port_mask learn_status         done high, one cycle
// config    cfg_valid cfg_ready cfg_index cfg_data              cfg_valid and cfg_ready
//
// Once an item heads the queue, the table scan reads one row of four entries per cycle
// from the banked table RAM; the next item leaves the queue only once the last has its result.
// A two-entry queue sits behind the input; busy is high while it is full.
// Reset clears all table valid bits at once and loads port_count 16, age_limit 300.
// Results cannot be held off: done pulses for one cycle per item, in input order.
module mac_learning_switch (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [mls_pkg::PORT_W-1:0]     in_port,
	input  logic [mls_pkg::MAC_W-1:0]      src_mac,
	input  logic [mls_pkg::MAC_W-1:0]      dst_mac,
	input  logic [mls_pkg::TIME_W-1:0]     arrival_time,
	output logic                           done,
	output logic [1:0]                     action,
	output logic [mls_pkg::PORT_W-1:0]     out_port,
	output logic [mls_pkg::MASK_W-1:0]     port_mask,
	output logic [1:0]                     learn_status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mls_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mls_pkg::*;

	logic [PCNT_W-1:0] port_count_q;
	logic [TIME_W-1:0] age_limit_q;
	q_status_t         q_status;
	logic              push;
	logic              pop;
	item_t             in_item;
	item_t             q_item;
	result_t           result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_count_q <= PORT_COUNT_RST;
			age_limit_q  <= AGE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PORT_COUNT: port_count_q <= cfg_data[PCNT_W-1:0];
				CFG_AGE_LIMIT:  age_limit_q  <= cfg_data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mls_front u_front (
		.start        (start),
		.busy         (busy),
		.in_port      (in_port),
		.src_mac      (src_mac),
		.dst_mac      (dst_mac),
		.arrival_time (arrival_time),
		.port_count   (port_count_q),
		.q_status     (q_status),
		.push         (push),
		.item         (in_item)
	);

	mls_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_item),
		.pop    (pop),
		.rdata  (q_item),
		.status (q_status)
	);

	mls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_item    (q_item),
		.pop       (pop),
		.age_limit (age_limit_q),
		.done      (done),
		.result    (result)
	);

	assign action       = result.action;
	assign out_port     = result.out_port;
	assign port_mask    = result.port_mask;
	assign learn_status = result.learn_status;

endmodule

// ===== design/mls_checker.sv =====
module mls_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       done,
	input logic [1:0]                 action,
	input logic [mls_pkg::PORT_W-1:0] out_port,
	input logic [mls_pkg::MASK_W-1:0] port_mask,
	input logic [1:0]                 learn_status
);
	import mls_pkg::*;

	// a table scan separates any two results
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back results");

	a_drop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && action == ACT_DROP |-> port_mask == '0 && out_port == '0)
		else $error("drop with nonzero port or mask");

	a_fwd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		done && action == ACT_FWD |-> $onehot(port_mask) && port_mask[out_port])
		else $error("forward mask does not match out_port");

	a_flood_port: assert property (@(posedge clk) disable iff (!arst_n)
		done && action == ACT_FLOOD |-> out_port == '0)
		else $error("flood with nonzero out_port");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> action != 2'd3 && learn_status != 2'd3)
		else $error("reserved code on result");

endmodule

bind mac_learning_switch mls_checker u_mls_checker (.*);

// ===== tb/mac_learning_switch_tb.sv =====
module mac_learning_switch_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mls_pkg::*;

	localparam int CYCLE_LIMIT   = 500_000;
	localparam int TAIL_CYCLES   = 40;
	localparam int POOL_SIZE     = 160;

	localparam logic [MAC_W-1:0] MAC_A     = 48'h0012_3456_789A;
	localparam logic [MAC_W-1:0] MAC_B     = 48'h02AB_CDEF_0001;
	localparam logic [MAC_W-1:0] MAC_C     = 48'h0A00_0000_0002;
	localparam logic [MAC_W-1:0] MAC_D     = 48'h0E00_0000_0003;
	localparam logic [MAC_W-1:0] MAC_E     = 48'hFE11_2233_4455;
	localparam logic [MAC_W-1:0] MAC_F     = 48'h5C00_0000_0006;
	localparam logic [MAC_W-1:0] MAC_G     = 48'h7000_0000_0007;
	localparam logic [MAC_W-1:0] MAC_NEVER = 48'h0200_0000_0099;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [PORT_W-1:0]     in_port;
	logic [MAC_W-1:0]      src_mac;
	logic [MAC_W-1:0]      dst_mac;
	logic [TIME_W-1:0]     arrival_time;
	logic                  done;
	logic [1:0]            action;
	logic [PORT_W-1:0]     out_port;
	logic [MASK_W-1:0]     port_mask;
	logic [1:0]            learn_status;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow of the bridge: MAC table and registers
	logic              tbl_valid [TABLE_ENTRIES];
	logic [MAC_W-1:0]  tbl_mac   [TABLE_ENTRIES];
	logic [PORT_W-1:0] tbl_port  [TABLE_ENTRIES];
	logic [TIME_W-1:0] tbl_stamp [TABLE_ENTRIES];
	logic [PCNT_W-1:0] cur_port_count;
	logic [TIME_W-1:0] cur_age_limit;

	result_t           pending_decisions[$];
	logic [MAC_W-1:0]  mac_pool  [POOL_SIZE];
	logic [PORT_W-1:0] home_port [POOL_SIZE];
	logic [TIME_W-1:0] tick_count;
	int                mismatches = 0;
	int                cycles = 0;

	mac_learning_switch uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_port(in_port),
		.src_mac(src_mac),
		.dst_mac(dst_mac),
		.arrival_time(arrival_time),
		.done(done),
		.action(action),
		.out_port(out_port),
		.port_mask(port_mask),
		.learn_status(learn_status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("mac_learning_switch_tb: done, errors");
			$finish;
		end
	end

	// learn the source first, then look up the destination
	function automatic result_t forward_decision(input logic [PORT_W-1:0] port,
			input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
			input logic [TIME_W-1:0] now);
		result_t           r;
		int                hit;
		int                slot;
		int                n;
		logic              fresh;
		logic [PORT_W-1:0] fwd;
		logic [TIME_W-1:0] age;
		hit = -1;
		slot = -1;
		fresh = 1'b0;
		fwd = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (hit < 0 && tbl_valid[i] && tbl_mac[i] == src)
				hit = i;
			if (slot < 0 && !tbl_valid[i])
				slot = i;
		end
		if (hit >= 0) begin
			tbl_port[hit] = port;
			tbl_stamp[hit] = now;
			r.learn_status = LEARN_REFRESH;
		end else if (slot >= 0) begin
			tbl_valid[slot] = 1'b1;
			tbl_mac[slot] = src;
			tbl_port[slot] = port;
			tbl_stamp[slot] = now;
			r.learn_status = LEARN_NEW;
		end else begin
			r.learn_status = LEARN_FULL;
		end

		if (!dst[GROUP_BIT]) begin
			hit = -1;
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (hit < 0 && tbl_valid[i] && tbl_mac[i] == dst)
					hit = i;
			if (hit >= 0) begin
				age = now - tbl_stamp[hit];
				if (age < cur_age_limit) begin
					fresh = 1'b1;
					fwd = tbl_port[hit];
				end
			end
		end

		if (fresh && fwd == port) begin
			r.action = ACT_DROP;
			r.out_port = '0;
			r.port_mask = '0;
		end else if (fresh) begin
			r.action = ACT_FWD;
			r.out_port = fwd;
			r.port_mask = MASK_W'(1) << fwd;
		end else begin
			n = (cur_port_count > NUM_PORTS) ? NUM_PORTS : int'(cur_port_count);
			r.action = ACT_FLOOD;
			r.out_port = '0;
			r.port_mask = '0;
			for (int i = 0; i < n; i++)
				if (i != port)
					r.port_mask[i] = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_decisions.size() == 0) begin
				$error("result with nothing outstanding: action %0d out_port %0d mask %h",
					action, out_port, port_mask);
				mismatches++;
			end else begin
				exp_r = pending_decisions.pop_front();
				if (action !== exp_r.action) begin
					$error("action: expected %0d, actual %0d", exp_r.action, action);
					mismatches++;
				end
				if (out_port !== exp_r.out_port) begin
					$error("out_port: expected %0d, actual %0d", exp_r.out_port, out_port);
					mismatches++;
				end
				if (port_mask !== exp_r.port_mask) begin
					$error("port_mask: expected %h, actual %h", exp_r.port_mask, port_mask);
					mismatches++;
				end
				if (learn_status !== exp_r.learn_status) begin
					$error("learn_status: expected %0d, actual %0d",
						exp_r.learn_status, learn_status);
					mismatches++;
				end
			end
		end
	end

	function automatic logic [MAC_W-1:0] rand_mac();
		return MAC_W'({$urandom(), $urandom()});
	endfunction

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 80);
	endfunction

	// start stays high on return so the next frame can follow back to back
	task automatic send_frame(input logic [PORT_W-1:0] port, input logic [MAC_W-1:0] src,
			input logic [MAC_W-1:0] dst, input logic [TIME_W-1:0] now);
		in_port <= port;
		src_mac <= src;
		dst_mac <= dst;
		arrival_time <= now;
		if (start !== 1'b1)
			start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		pending_decisions.push_back(forward_decision(port, src, dst, now));
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_decisions.size() != 0);
	endtask

	// write both registers while the bridge is idle
	task automatic set_config(input logic [PCNT_W-1:0] pc, input logic [TIME_W-1:0] age);
		drain_results();
		cfg_index <= CFG_PORT_COUNT;
		cfg_data <= CFG_DATA_W'(pc);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cur_port_count = pc;
		cfg_index <= CFG_AGE_LIMIT;
		cfg_data <= age;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cur_age_limit = age;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_learn_forward();
		send_frame(4'd0, MAC_A, MAC_B, 32'd1000);
		send_frame(4'd15, MAC_B, MAC_A, 32'd1001);
		// destination equals source: hits the entry just refreshed
		send_frame(4'd15, MAC_B, MAC_B, 32'd1002);
		send_frame(4'd7, MAC_A, MAC_B | (48'd1 << GROUP_BIT), 32'd1003);
		send_frame(4'd9, 48'hFFFF_FFFF_FFFF, 48'h0, 32'd1004);
		send_frame(4'd5, 48'h0, 48'hFFFF_FFFF_FFFF, 32'd1005);
		send_frame(4'd4, MAC_C, MAC_A, 32'd1006);
	endtask

	task automatic test_aging();
		// one tick short of the limit, then exactly at it
		send_frame(4'd2, MAC_C, MAC_B, 32'd1301);
		send_frame(4'd2, MAC_C, MAC_B, 32'd1302);
		send_frame(4'd3, MAC_D, MAC_C, 32'hFFFF_FFF0);
		// age across the wrap of the tick counter
		send_frame(4'd6, MAC_E, MAC_D, 32'h0000_0010);
		send_frame(4'd6, MAC_E, MAC_D, 32'hFFFF_FFFF);
		set_config(5'd16, 32'd0);
		send_frame(4'd1, MAC_D, MAC_E, 32'd0);
		set_config(5'd16, 32'd1);
		send_frame(4'd1, MAC_E, MAC_E, 32'd0);
		set_config(5'd16, 32'hFFFF_FFFF);
		send_frame(4'd8, MAC_F, MAC_B, 32'd0);
	endtask

	task automatic test_port_count();
		set_config(5'd0, 32'hFFFF_FFFF);
		send_frame(4'd3, MAC_F, MAC_NEVER, 32'd5);
		set_config(5'd1, 32'hFFFF_FFFF);
		send_frame(4'd0, MAC_F, MAC_NEVER, 32'd6);
		send_frame(4'd5, MAC_F, MAC_NEVER, 32'd7);
		set_config(5'd31, 32'hFFFF_FFFF);
		send_frame(4'd15, MAC_F, MAC_NEVER, 32'd8);
		set_config(5'd7, 32'hFFFF_FFFF);
		// ingress outside the flood range, then a forward port outside it
		send_frame(4'd10, MAC_F, MAC_NEVER, 32'd9);
		send_frame(4'd1, MAC_G, MAC_B, 32'd10);
	endtask

	task automatic random_traffic(input int count, input int pool_hi, input int stranger_pct);
		int                pick;
		int                peer;
		int                choice;
		int                calm_left;
		logic [PORT_W-1:0] port;
		logic [MAC_W-1:0]  src;
		logic [MAC_W-1:0]  dst;
		calm_left = 0;
		for (int k = 0; k < count; k++) begin
			if (k % 64 == 0)
				calm_left = ($urandom_range(0, 2) == 0) ? $urandom_range(16, 48) : 0;
			pick = $urandom_range(0, pool_hi - 1);
			if ($urandom_range(0, 99) < stranger_pct) begin
				src = rand_mac();
				port = PORT_W'($urandom_range(0, 15));
			end else begin
				src = mac_pool[pick];
				port = ($urandom_range(0, 3) == 0) ? PORT_W'($urandom_range(0, 15))
					: home_port[pick];
			end
			peer = $urandom_range(0, pool_hi - 1);
			choice = $urandom_range(0, 19);
			if (choice < 12) begin
				dst = mac_pool[peer];
			end else if (choice < 14) begin
				dst = src;
			end else if (choice < 16) begin
				dst = mac_pool[peer];
				dst[GROUP_BIT] = 1'b1;
			end else begin
				dst = rand_mac();
			end
			// advance time mostly in small steps, now and then jump anywhere
			choice = $urandom_range(0, 9);
			if (choice < 6)
				tick_count = tick_count + $urandom_range(0, 3);
			else if (choice < 9)
				tick_count = tick_count + $urandom_range(0, 400);
			else
				tick_count = $urandom();
			if (calm_left > 0)
				calm_left--;
			else
				pause_sender(sender_gap());
			if ($urandom_range(0, 199) == 0)
				drain_results();
			send_frame(port, src, dst, tick_count);
		end
	endtask

	task automatic test_random_learning();
		set_config(5'd16, 32'd300);
		random_traffic(400, 40, 3);
	endtask

	task automatic test_random_table_full();
		set_config(5'd31, 32'hFFFF_FFFF);
		random_traffic(350, 120, 10);
	endtask

	task automatic test_random_settings();
		logic [PCNT_W-1:0] pc;
		logic [TIME_W-1:0] age;
		for (int p = 0; p < 4; p++) begin
			case ($urandom_range(0, 4))
				0: pc = 5'd0;
				1: pc = 5'd1;
				2: pc = 5'd16;
				3: pc = 5'd31;
				default: pc = PCNT_W'($urandom_range(0, 31));
			endcase
			case ($urandom_range(0, 3))
				0: age = 32'd1;
				1: age = 32'd300;
				2: age = 32'hFFFF_FFFF;
				default: age = $urandom_range(2, 1000);
			endcase
			set_config(pc, age);
			random_traffic(100, POOL_SIZE, 10);
		end
	endtask

	task automatic test_random_short_life();
		set_config(PCNT_W'($urandom_range(2, 16)), 32'd1);
		random_traffic(400, POOL_SIZE, 5);
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		in_port <= '0;
		src_mac <= '0;
		dst_mac <= '0;
		arrival_time <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cur_port_count = PORT_COUNT_RST;
		cur_age_limit = AGE_LIMIT_RST;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_mac[i] = '0;
			tbl_port[i] = '0;
			tbl_stamp[i] = '0;
		end
		for (int i = 0; i < POOL_SIZE; i++) begin
			mac_pool[i] = rand_mac();
			// keep most pool addresses unicast so lookups happen
			if (i % 8 != 0)
				mac_pool[i][GROUP_BIT] = 1'b0;
			home_port[i] = PORT_W'($urandom_range(0, 15));
		end
		tick_count = $urandom();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_learn_forward();
		test_aging();
		test_port_count();
		test_random_learning();
		test_random_table_full();
		test_random_settings();
		test_random_short_life();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_decisions.size() == 0)
			$display("mac_learning_switch_tb: done, clean");
		else
			$display("mac_learning_switch_tb: done, errors");
		$finish;
	end

endmodule
